/* hw/rtl/fbtr_pkg.sv */
`default_nettype none
package fbtr_pkg;

    // operation codes
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_DOUBLE = 3'd2;
    localparam logic [2:0] KIND_FILL   = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7E;
    localparam logic [7:0] DEGREE_CODE = 8'h7E;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;

    // one queued operation
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] page;
        logic [7:0] slot;
        logic [7:0] code;
        logic [7:0] span_start;
        logic [7:0] span_end;
        logic       span_set;
        logic [6:0] read_column;
    } fbtr_op_t;

    typedef logic [39:0] glyph_t;

    // 5x8 font, column 0 in bits 7:0
    function automatic glyph_t font_glyph(input logic [6:0] idx);
        glyph_t g;
        case (idx)
            7'd0:  g = {8'h00,8'h00,8'h00,8'h00,8'h00};
            7'd1:  g = {8'h00,8'h00,8'h5F,8'h00,8'h00};
            7'd2:  g = {8'h00,8'h07,8'h00,8'h07,8'h00};
            7'd3:  g = {8'h14,8'h7F,8'h14,8'h7F,8'h14};
            7'd4:  g = {8'h12,8'h2A,8'h7F,8'h2A,8'h24};
            7'd5:  g = {8'h62,8'h64,8'h08,8'h13,8'h23};
            7'd6:  g = {8'h50,8'h22,8'h55,8'h49,8'h36};
            7'd7:  g = {8'h00,8'h00,8'h03,8'h05,8'h00};
            7'd8:  g = {8'h00,8'h41,8'h22,8'h1C,8'h00};
            7'd9:  g = {8'h00,8'h1C,8'h22,8'h41,8'h00};
            7'd10: g = {8'h08,8'h04,8'h7F,8'h04,8'h08};
            7'd11: g = {8'h08,8'h08,8'h3E,8'h08,8'h08};
            7'd12: g = {8'h00,8'h00,8'h30,8'h50,8'h00};
            7'd13: g = {8'h08,8'h08,8'h08,8'h08,8'h08};
            7'd14: g = {8'h00,8'h00,8'h60,8'h60,8'h00};
            7'd15: g = {8'h02,8'h04,8'h08,8'h10,8'h20};
            7'd16: g = {8'h3E,8'h45,8'h49,8'h51,8'h3E};
            7'd17: g = {8'h00,8'h40,8'h7F,8'h42,8'h00};
            7'd18: g = {8'h46,8'h49,8'h51,8'h61,8'h42};
            7'd19: g = {8'h31,8'h4B,8'h45,8'h41,8'h21};
            7'd20: g = {8'h10,8'h7F,8'h12,8'h14,8'h18};
            7'd21: g = {8'h39,8'h45,8'h45,8'h45,8'h27};
            7'd22: g = {8'h30,8'h49,8'h49,8'h4A,8'h3C};
            7'd23: g = {8'h03,8'h05,8'h09,8'h71,8'h01};
            7'd24: g = {8'h36,8'h49,8'h49,8'h49,8'h36};
            7'd25: g = {8'h1E,8'h29,8'h49,8'h49,8'h06};
            7'd26: g = {8'h00,8'h00,8'h36,8'h36,8'h00};
            7'd27: g = {8'h00,8'h00,8'h36,8'h56,8'h00};
            7'd28: g = {8'h00,8'h41,8'h22,8'h14,8'h08};
            7'd29: g = {8'h14,8'h14,8'h14,8'h14,8'h14};
            7'd30: g = {8'h08,8'h14,8'h22,8'h41,8'h00};
            7'd31: g = {8'h06,8'h09,8'h51,8'h01,8'h02};
            7'd32: g = {8'h3E,8'h41,8'h79,8'h49,8'h32};
            7'd33: g = {8'h7E,8'h11,8'h11,8'h11,8'h7E};
            7'd34: g = {8'h36,8'h49,8'h49,8'h49,8'h7F};
            7'd35: g = {8'h22,8'h41,8'h41,8'h41,8'h3E};
            7'd36: g = {8'h3E,8'h41,8'h41,8'h41,8'h7F};
            7'd37: g = {8'h41,8'h49,8'h49,8'h49,8'h7F};
            7'd38: g = {8'h01,8'h01,8'h09,8'h09,8'h7F};
            7'd39: g = {8'h7A,8'h49,8'h49,8'h41,8'h3E};
            7'd40: g = {8'h7F,8'h08,8'h08,8'h08,8'h7F};
            7'd41: g = {8'h00,8'h41,8'h7F,8'h41,8'h00};
            7'd42: g = {8'h01,8'h3F,8'h41,8'h40,8'h20};
            7'd43: g = {8'h41,8'h22,8'h14,8'h08,8'h7F};
            7'd44: g = {8'h40,8'h40,8'h40,8'h40,8'h7F};
            7'd45: g = {8'h7F,8'h02,8'h0C,8'h02,8'h7F};
            7'd46: g = {8'h7F,8'h10,8'h08,8'h04,8'h7F};
            7'd47: g = {8'h3E,8'h41,8'h41,8'h41,8'h3E};
            7'd48: g = {8'h06,8'h09,8'h09,8'h09,8'h7F};
            7'd49: g = {8'h5E,8'h21,8'h51,8'h41,8'h3E};
            7'd50: g = {8'h46,8'h29,8'h19,8'h09,8'h7F};
            7'd51: g = {8'h31,8'h49,8'h49,8'h49,8'h46};
            7'd52: g = {8'h01,8'h01,8'h7F,8'h01,8'h01};
            7'd53: g = {8'h3F,8'h40,8'h40,8'h40,8'h3F};
            7'd54: g = {8'h1F,8'h20,8'h40,8'h20,8'h1F};
            7'd55: g = {8'h7F,8'h20,8'h18,8'h20,8'h7F};
            7'd56: g = {8'h63,8'h14,8'h08,8'h14,8'h63};
            7'd57: g = {8'h07,8'h08,8'h70,8'h08,8'h07};
            7'd58: g = {8'h43,8'h45,8'h49,8'h51,8'h61};
            7'd59: g = {8'h00,8'h41,8'h41,8'h7F,8'h00};
            7'd60: g = {8'h20,8'h10,8'h08,8'h04,8'h02};
            7'd61: g = {8'h00,8'h7F,8'h41,8'h41,8'h00};
            7'd62: g = {8'h04,8'h02,8'h01,8'h02,8'h04};
            7'd63: g = {8'h40,8'h40,8'h40,8'h40,8'h40};
            7'd64: g = {8'h00,8'h04,8'h02,8'h01,8'h00};
            7'd65: g = {8'h78,8'h54,8'h54,8'h54,8'h20};
            7'd66: g = {8'h38,8'h44,8'h44,8'h48,8'h7F};
            7'd67: g = {8'h20,8'h44,8'h44,8'h44,8'h38};
            7'd68: g = {8'h7F,8'h48,8'h44,8'h44,8'h38};
            7'd69: g = {8'h18,8'h54,8'h54,8'h54,8'h38};
            7'd70: g = {8'h02,8'h01,8'h09,8'h7E,8'h08};
            7'd71: g = {8'h14,8'h12,8'h12,8'h19,8'h08};
            7'd72: g = {8'h78,8'h04,8'h04,8'h08,8'h7F};
            7'd73: g = {8'h00,8'h40,8'h7D,8'h44,8'h00};
            7'd74: g = {8'h00,8'h3D,8'h44,8'h40,8'h20};
            7'd75: g = {8'h63,8'h14,8'h08,8'h7F,8'h00};
            7'd76: g = {8'h00,8'h40,8'h7F,8'h41,8'h00};
            7'd77: g = {8'h78,8'h04,8'h18,8'h04,8'h7C};
            7'd78: g = {8'h78,8'h04,8'h04,8'h08,8'h7C};
            7'd79: g = {8'h38,8'h44,8'h44,8'h44,8'h38};
            7'd80: g = {8'h08,8'h14,8'h14,8'h14,8'h7C};
            7'd81: g = {8'h7C,8'h14,8'h14,8'h14,8'h08};
            7'd82: g = {8'h04,8'h04,8'h08,8'h7C,8'h00};
            7'd83: g = {8'h20,8'h54,8'h54,8'h54,8'h48};
            7'd84: g = {8'h20,8'h40,8'h44,8'h3F,8'h04};
            7'd85: g = {8'h7C,8'h20,8'h40,8'h40,8'h3C};
            7'd86: g = {8'h1C,8'h20,8'h40,8'h20,8'h1C};
            7'd87: g = {8'h3C,8'h40,8'h30,8'h40,8'h3C};
            7'd88: g = {8'h44,8'h28,8'h10,8'h28,8'h44};
            7'd89: g = {8'h3C,8'h50,8'h50,8'h50,8'h0C};
            7'd90: g = {8'h44,8'h4C,8'h54,8'h64,8'h44};
            7'd91: g = {8'h00,8'h41,8'h36,8'h08,8'h00};
            7'd92: g = {8'h00,8'h00,8'h7F,8'h00,8'h00};
            7'd93: g = {8'h00,8'h08,8'h36,8'h41,8'h00};
            7'd94: g = {8'h08,8'h10,8'h08,8'h04,8'h08};
            default: g = '0;
        endcase
        return g;
    endfunction

    // small ring used for the degree sign
    localparam glyph_t RING_GLYPH = {8'h00, 8'h00, 8'h02, 8'h05, 8'h02};

    // each source bit doubled: nibble to byte
    function automatic logic [7:0] widen_nibble(input logic [3:0] n);
        logic [7:0] w;
        for (int i = 0; i < 4; i++)
        begin
            w[2*i]   = n[i];
            w[2*i+1] = n[i];
        end
        return w;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/fbtr_front.sv */
`default_nettype none
// accepts input words into a two-entry queue
module fbtr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fbtr_pkg::fbtr_op_t in_op,
    output logic                    q_valid,
    input  wire logic               q_take,
    output fbtr_pkg::fbtr_op_t      q_op
);
    import fbtr_pkg::*;

    fbtr_op_t   slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_op     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // queue pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_op;
    end
endmodule
`default_nettype wire

/* hw/rtl/fbtr_back.sv */
`default_nettype none
// carries out one operation at a time on the frame store
module fbtr_back #(
    parameter int PAGE_COUNT   = 8,
    parameter int COLUMN_COUNT = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_take,
    input  wire fbtr_pkg::fbtr_op_t q_op,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              read_byte
);
    import fbtr_pkg::*;

    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW    = $clog2(COLUMN_COUNT);
    localparam int AW    = PW + CW;
    // store is addressed as {page, column}, so it spans the full address range
    localparam int DEPTH = 1 << AW;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_WAIT  = 7'b0001000,
        ST_WR    = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;

    fbtr_op_t    op_reg;
    glyph_t      glyph_reg;
    logic [8:0]  col_reg, col_next;      // current target column
    logic [2:0]  idx_reg, idx_next;      // glyph column index
    logic [1:0]  sub_reg, sub_next;      // double: bit0 column half, bit1 lower page
    logic [AW:0] clr_reg, clr_next;
    logic        clr_busy_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  res_next;
    logic        res_load;

    logic [7:0]  gcol;
    logic [7:0]  wmask;
    logic [PW:0] tgt_page;
    logic        col_ok;
    logic        printable;
    glyph_t      glyph_pick;
    logic [11:0] dbl_base;

    assign out_valid = out_valid_reg;
    assign read_byte = out_byte_reg;
    assign q_take    = (state_reg == ST_IDLE) && !clr_busy_reg && q_valid;

    assign printable = (q_op.code >= GLYPH_FIRST) && (q_op.code <= GLYPH_LAST);
    assign dbl_base  = {q_op.slot, 3'b000} + {1'b0, q_op.slot, 2'b00};

    always_comb
    begin
        glyph_pick = font_glyph(7'(q_op.code - GLYPH_FIRST));
        if (q_op.kind == KIND_CHAR && q_op.code == DEGREE_CODE)
            glyph_pick = RING_GLYPH;
    end

    // current glyph column and mask
    always_comb
    begin
        gcol = 8'h00;
        case (idx_reg)
            3'd0: gcol = glyph_reg[7:0];
            3'd1: gcol = glyph_reg[15:8];
            3'd2: gcol = glyph_reg[23:16];
            3'd3: gcol = glyph_reg[31:24];
            3'd4: gcol = glyph_reg[39:32];
            default: gcol = 8'h00;
        endcase
        if (op_reg.kind == KIND_DOUBLE)
            wmask = widen_nibble(sub_reg[1] ? gcol[7:4] : gcol[3:0]);
        else
            wmask = gcol;
        tgt_page = (PW+1)'(op_reg.page) + {{PW{1'b0}}, (op_reg.kind == KIND_DOUBLE) & sub_reg[1]};
        col_ok   = (col_reg < 9'(COLUMN_COUNT));
    end

    assign mem_raddr = AW'({tgt_page[PW-1:0], col_reg[CW-1:0]});

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = mem_raddr;
        mem_wdata  = rdata_reg | wmask;
        res_load   = 1'b0;
        res_next   = 8'h00;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_busy_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = clr_reg[AW-1:0];
                    mem_wdata = 8'h00;
                    clr_next  = clr_reg + 1'b1;
                end
                else if (q_valid)
                begin
                    idx_next = 3'd0;
                    sub_next = 2'd0;
                    state_next = ST_DONE;
                    case (q_op.kind)
                        KIND_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        KIND_CHAR:
                        begin
                            col_next = {1'b0, 8'(q_op.slot * 3'd6)};
                            if ({1'b0, q_op.page} < 5'(PAGE_COUNT) && printable)
                                state_next = ST_RD;
                        end
                        KIND_DOUBLE:
                        begin
                            col_next = dbl_base[8:0];
                            if ({1'b0, q_op.page} <= 5'(PAGE_COUNT - 2) && printable
                                && dbl_base[11:9] == 3'd0)
                                state_next = ST_RD;
                            else if ({1'b0, q_op.page} <= 5'(PAGE_COUNT - 2) && printable)
                                state_next = ST_DONE;
                        end
                        KIND_FILL:
                        begin
                            col_next = {1'b0, q_op.span_start};
                            if ({1'b0, q_op.page} < 5'(PAGE_COUNT)
                                && q_op.span_start <= q_op.span_end)
                                state_next = ST_FILL;
                        end
                        KIND_READ:
                        begin
                            col_next = {2'b00, q_op.read_column};
                            state_next = ST_WAIT;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wdata = 8'h00;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    state_next = ST_DONE;
            end
            ST_RD:
            begin
                // decide what this step does before the read returns
                if (op_reg.kind == KIND_DOUBLE)
                begin
                    if (gcol == 8'h00)
                    begin
                        idx_next = idx_reg + 3'd1;
                        col_next = col_reg + 9'd2;
                        if (idx_reg == 3'd4)
                            state_next = ST_DONE;
                    end
                    else if (col_reg + 9'd1 >= 9'(COLUMN_COUNT)
                             && sub_reg == 2'd0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_WAIT;
                end
                else
                begin
                    if (col_ok)
                        state_next = ST_WAIT;
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        col_next = col_reg + 9'd1;
                        if (idx_reg == 3'd4)
                            state_next = ST_DONE;
                    end
                end
            end
            ST_WAIT:
            begin
                if (op_reg.kind == KIND_READ)
                begin
                    state_next = ST_WR;
                end
                else
                    state_next = ST_WR;
            end
            ST_WR:
            begin
                if (op_reg.kind == KIND_READ)
                begin
                    // read data stays in rdata_reg while the address holds
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we = 1'b1;
                    state_next = ST_RD;
                    if (op_reg.kind == KIND_DOUBLE)
                    begin
                        sub_next = sub_reg + 2'd1;
                        if (sub_reg[0])
                            col_next = col_reg - 9'd1;
                        else
                            col_next = col_reg + 9'd1;
                        if (sub_reg == 2'd3)
                        begin
                            col_next = col_reg + 9'd1;
                            idx_next = idx_reg + 3'd1;
                            if (idx_reg == 3'd4)
                                state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        col_next = col_reg + 9'd1;
                        if (idx_reg == 3'd4)
                            state_next = ST_DONE;
                    end
                end
            end
            ST_FILL:
            begin
                mem_we    = col_ok;
                mem_waddr = AW'({op_reg.page[PW-1:0], col_reg[CW-1:0]});
                mem_wdata = op_reg.span_set ? BYTE_ONES : 8'h00;
                col_next  = col_reg + 9'd1;
                if (col_reg[7:0] == op_reg.span_end || !col_ok)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_load   = 1'b1;
                    if (op_reg.kind == KIND_READ && {1'b0, op_reg.page} < 5'(PAGE_COUNT)
                        && col_ok)
                        res_next = rdata_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= '0;
            clr_busy_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (clr_busy_reg && clr_reg == (AW+1)'(DEPTH - 1))
                clr_busy_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
        end
    end

    // operation and result payload
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        idx_reg <= idx_next;
        sub_reg <= sub_next;
        if (q_take)
        begin
            op_reg    <= q_op;
            glyph_reg <= glyph_pick;
        end
        if (res_load)
            out_byte_reg <= res_next;
    end
endmodule
`default_nettype wire

/* hw/rtl/framebuffer_text_renderer.sv */
`default_nettype none
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  kind page char_slot char_code span_* read_column
// out      output     out_valid / out_stall read_byte
//
// chars and doubles are drawn by a read-modify-write of the frame store.
// clear walks the store one byte a cycle.
// after reset the same clearing pass runs before the first word is carried out.
// a two-word queue keeps accepting, until it is full, while the back end works or its result is stalled.
module framebuffer_text_renderer #(
    parameter int PAGE_COUNT   = 8,
    parameter int COLUMN_COUNT = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] kind,
    input  wire logic [2:0] page,
    input  wire logic [7:0] char_slot,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] span_start,
    input  wire logic [7:0] span_end,
    input  wire logic       span_set,
    input  wire logic [6:0] read_column,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_byte
);
    import fbtr_pkg::*;

    fbtr_op_t in_op, q_op;
    logic     q_valid, q_take;

    // pack the input word
    always_comb
    begin
        in_op.kind        = kind;
        in_op.page        = {1'b0, page};
        in_op.slot        = char_slot;
        in_op.code        = char_code;
        in_op.span_start  = span_start;
        in_op.span_end    = span_end;
        in_op.span_set    = span_set;
        in_op.read_column = read_column;
    end

    fbtr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_op    (in_op),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_op     (q_op)
    );

    fbtr_back #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_op      (q_op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_byte (read_byte)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_framebuffer_text_renderer.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_framebuffer_text_renderer;
    import fbtr_pkg::*;

    localparam int PAGES = 8;
    localparam int COLS  = 128;

    // scoreboard: shadow frame store and queue of expected read bytes
    class frame_scoreboard;
        byte unsigned shadow [PAGES*COLS];
        byte unsigned pending_bytes [$];
        int errors;

        function new();
            foreach (shadow[i]) shadow[i] = 0;
            errors = 0;
        endfunction

        // 5x8 font, column 0 first
        function automatic logic [39:0] font_row(int idx);
            logic [39:0] f [95] = '{
                40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
                40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
                40'h001C224100, 40'h0041221C00, 40'h08047F0408, 40'h08083E0808,
                40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
                40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
                40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
                40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
                40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
                40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
                40'h7F4141413E, 40'h7F49494941, 40'h7F09090101, 40'h3E4149497A,
                40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
                40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
                40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
                40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
                40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
                40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
                40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
                40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0819121214,
                40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F081463,
                40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
                40'h7C14141408, 40'h081414147C, 40'h007C080404, 40'h4854545420,
                40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
                40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
                40'h00007F0000, 40'h0041360800, 40'h0804081008};
            return f[idx];
        endfunction

        function automatic byte unsigned glyph_col(logic [39:0] g, int i);
            return g[39-8*i -: 8];
        endfunction

        // apply one accepted word to the shadow store and note its answer
        function void note_word(logic [2:0] k, logic [2:0] pg, logic [7:0] slot,
                                logic [7:0] code, logic [7:0] s0, logic [7:0] s1,
                                logic st, logic [6:0] rc);
            logic [39:0] g;
            int base, c, left, dp;
            byte unsigned v, m;
            byte unsigned answer;
            answer = 0;
            case (k)
                KIND_CLEAR: foreach (shadow[i]) shadow[i] = 0;
                KIND_CHAR:
                begin
                    if (code >= GLYPH_FIRST && code <= GLYPH_LAST)
                    begin
                        g = (code == DEGREE_CODE) ? 40'h0205020000 : font_row(code - 32);
                        base = (int'(slot) * 6) & 8'hFF;
                        for (int i = 0; i < 5; i++)
                        begin
                            c = base + i;
                            if (c < COLS) shadow[pg*COLS + c] |= glyph_col(g, i);
                        end
                    end
                end
                KIND_DOUBLE:
                begin
                    if (pg <= PAGES - 2 && code >= GLYPH_FIRST && code <= GLYPH_LAST)
                    begin
                        g = font_row(code - 32);
                        base = int'(slot) * 12;
                        for (int i = 0; i < 5; i++)
                        begin
                            v = glyph_col(g, i);
                            left = base + 2*i;
                            if (v == 0) continue;
                            if (left + 1 >= COLS) break;
                            for (int b = 0; b < 8; b++)
                                if (v[b])
                                begin
                                    dp = pg + b/4;
                                    m = 8'd3 << ((2*b) & 7);
                                    shadow[dp*COLS + left] |= m;
                                    shadow[dp*COLS + left + 1] |= m;
                                end
                        end
                    end
                end
                KIND_FILL:
                    if (s0 <= s1)
                        for (int i = s0; i <= s1 && i < COLS; i++)
                            shadow[pg*COLS + i] = st ? BYTE_ONES : 8'h00;
                KIND_READ: answer = shadow[pg*COLS + rc];
                default: ;
            endcase
            pending_bytes.push_back(answer);
        endfunction

        function void check_byte(logic [7:0] got);
            byte unsigned want;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got !== want)
            begin
                $display("%0t: read_byte expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid, in_stall;
    logic [2:0] kind;
    logic [2:0] page;
    logic [7:0] char_slot, char_code, span_start, span_end;
    logic span_set;
    logic [6:0] read_column;
    logic out_valid, out_stall;
    logic [7:0] read_byte;

    frame_scoreboard sb;
    int burst_left;

    framebuffer_text_renderer dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .page(page), .char_slot(char_slot), .char_code(char_code),
        .span_start(span_start), .span_end(span_end), .span_set(span_set),
        .read_column(read_column), .out_valid(out_valid), .out_stall(out_stall),
        .read_byte(read_byte)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // send one word, with burst gaps before it
    task automatic send_word(logic [2:0] k, logic [2:0] pg, logic [7:0] slot,
                             logic [7:0] code, logic [7:0] s0, logic [7:0] s1,
                             logic st, logic [6:0] rc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k; page <= pg; char_slot <= slot; char_code <= code;
        span_start <= s0; span_end <= s1; span_set <= st; read_column <= rc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(k, pg, slot, code, s0, s1, st, rc);
    endtask

    task automatic send_read(logic [2:0] pg, logic [6:0] rc);
        send_word(KIND_READ, pg, 0, 0, 0, 0, 0, rc);
    endtask

    // random word, mostly drawing and reading
    task automatic send_random();
        int sel;
        logic [2:0] k;
        logic [7:0] slot;
        sel = $urandom_range(0, 99);
        if (sel < 1) k = KIND_CLEAR;
        else if (sel < 30) k = KIND_CHAR;
        else if (sel < 42) k = KIND_DOUBLE;
        else if (sel < 50) k = KIND_FILL;
        else if (sel < 95) k = KIND_READ;
        else k = $urandom_range(5, 7);
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 22);
        if (k == KIND_DOUBLE && $urandom_range(0, 1)) slot = $urandom_range(0, 11);
        send_word(k, $urandom_range(0, 7), slot,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(32, 126),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                  $urandom_range(0, 127));
    endtask

    // output side: stall pattern and checking
    initial
    begin
        int phase;
        out_stall = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.check_byte(read_byte);
            phase++;
            if (phase % 400 < 100) out_stall <= 1'b0;
            else out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // stimulus
    initial
    begin
        int idle;
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_CLEAR; page = 0; char_slot = 0; char_code = 0;
        span_start = 0; span_end = 0; span_set = 0; read_column = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset state, glyphs, degree ring, clipping, edges
        send_read(0, 0);
        send_read(7, 127);
        send_word(KIND_CHAR, 0, 0, 8'h41, 0, 0, 0, 0);
        send_read(0, 0);
        send_read(0, 4);
        send_word(KIND_CHAR, 1, 1, DEGREE_CODE, 0, 0, 0, 0);
        send_read(1, 7);
        send_word(KIND_CHAR, 2, 21, 8'h57, 0, 0, 0, 0);
        send_read(2, 127);
        send_word(KIND_CHAR, 3, 255, 8'h30, 0, 0, 0, 0);
        send_word(KIND_CHAR, 3, 0, 8'h1F, 0, 0, 0, 0);
        send_word(KIND_CHAR, 3, 0, 8'hFF, 0, 0, 0, 0);
        send_word(KIND_DOUBLE, 6, 10, 8'h4D, 0, 0, 0, 0);
        send_read(6, 120);
        send_read(7, 121);
        send_word(KIND_DOUBLE, 7, 0, 8'h4D, 0, 0, 0, 0);
        send_word(KIND_DOUBLE, 0, 0, DEGREE_CODE, 0, 0, 0, 0);
        send_read(0, 2);
        send_word(KIND_FILL, 4, 0, 0, 8'd0, 8'd255, 1'b1, 0);
        send_read(4, 127);
        send_word(KIND_FILL, 4, 0, 0, 8'd10, 8'd5, 1'b0, 0);
        send_word(KIND_FILL, 4, 0, 0, 8'd100, 8'd100, 1'b0, 0);
        send_read(4, 100);
        send_word(3'd7, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 7'h7F);
        send_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_read(4, 127);

        // random part
        for (int n = 0; n < 1400; n++) send_random();
        in_valid <= 1'b0;

        // drain
        idle = 0;
        while (sb.pending_bytes.size() != 0 && idle < 200000)
        begin
            @(posedge clk);
            idle++;
        end
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
